### rtl/core/tcas_pkg.sv
// tcas_pkg: shared widths, transaction structs and the arctangent table
// for the triangle centroid, area and slope pipeline
// no dependencies
package tcas_pkg;

  localparam int CoordW   = 16;                // vertex coordinate width
  localparam int DiffW    = CoordW + 1;        // edge vector component
  localparam int SumW     = CoordW + 2;        // sum of three coordinates
  localparam int ProdW    = 2 * DiffW;         // edge component product
  localparam int NormW    = ProdW + 1;         // normal component
  localparam int MagW     = ProdW;             // normal magnitude
  localparam int HalfW    = MagW / 2;          // half of a magnitude for squaring
  localparam int SqW      = 70;                // sum of squares
  localparam int RootW    = SqW / 2;           // integer square root
  localparam int AreaW    = 35;
  localparam int SlopeW   = 16;
  localparam int CordW    = 44;                // cordic x and y
  localparam int AngW     = 26;                // cordic angle, degrees q16
  localparam int Steps    = 18;
  localparam int NormMsb  = 39;                // the larger cordic operand lands in [2^39, 2^40)
  localparam int ShW      = 6;
  localparam int RecipW   = 16;
  localparam logic [RecipW-1:0] Recip3 = 16'd43691;  // ceil(2^17 / 3)
  localparam int RecipSh  = 17;

  localparam int CrossLat = 7;
  localparam int CordLat  = Steps + 3;
  localparam int TotalLat = CrossLat + RootW + CordLat;

  localparam logic signed [AngW-1:0] Angle90  = AngW'(90 * 65536);
  localparam logic signed [AngW-1:0] Angle180 = AngW'(180 * 65536);

  typedef struct packed {
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] first_z;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic signed [CoordW-1:0] second_z;
    logic signed [CoordW-1:0] third_x;
    logic signed [CoordW-1:0] third_y;
    logic signed [CoordW-1:0] third_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [AreaW-1:0]         area;
    logic [SlopeW-1:0]        slope_degrees;
    logic                     degenerate;
  } tri_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic                     degen;
  } side_t;

  // atan(2^-i) in degrees, q16, rounded
  function automatic logic signed [AngW-1:0] atan_q16(input int i);
    logic signed [AngW-1:0] a;
    case (i)
      0:  a = AngW'(2949120);
      1:  a = AngW'(1740967);
      2:  a = AngW'(919879);
      3:  a = AngW'(466945);
      4:  a = AngW'(234379);
      5:  a = AngW'(117304);
      6:  a = AngW'(58666);
      7:  a = AngW'(29335);
      8:  a = AngW'(14668);
      9:  a = AngW'(7334);
      10: a = AngW'(3667);
      11: a = AngW'(1833);
      12: a = AngW'(917);
      13: a = AngW'(458);
      14: a = AngW'(229);
      15: a = AngW'(115);
      16: a = AngW'(57);
      17: a = AngW'(29);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/tcas_cross.sv
// tcas_cross: edge vectors, cross product normal, squared lengths and centroid
// depends on tcas_pkg
module tcas_cross (
  input  logic                                    clk,
  input  logic                                    en,
  input  tcas_pkg::tri_in_t                       tri_in,
  output logic [tcas_pkg::SqW-1:0]                sum_all,
  output logic [tcas_pkg::SqW-1:0]                sum_xy,
  output logic signed [tcas_pkg::NormW-1:0]       norm_z,
  output tcas_pkg::side_t                         side
);

  localparam int DW = tcas_pkg::DiffW;
  localparam int SW = tcas_pkg::SumW;
  localparam int PW = tcas_pkg::ProdW;
  localparam int NW = tcas_pkg::NormW;
  localparam int MW = tcas_pkg::MagW;
  localparam int HW = tcas_pkg::HalfW;
  localparam int QW = tcas_pkg::CoordW + 1;
  localparam int QP = QW + tcas_pkg::RecipW;
  localparam int QS = tcas_pkg::RecipSh;
  localparam int CW = tcas_pkg::CoordW;
  localparam int XW = tcas_pkg::SqW;

  // stage 1: input register
  tcas_pkg::tri_in_t p0;

  // stage 2: edges and coordinate sums
  logic signed [DW-1:0] ab_x, ab_y, ab_z, ac_x, ac_y, ac_z;
  logic signed [SW-1:0] sm_x, sm_y, sm_z;

  // stage 3: products and centroid scaling
  logic signed [PW-1:0] acy_abz, acz_aby, acz_abx, acx_abz, acx_aby, acy_abx;
  logic [QP-1:0]        q_x, q_y, q_z;
  logic                 neg_x3, neg_y3, neg_z3;

  // stage 4: normal and centroid
  logic signed [NW-1:0] n_x, n_y, n_z;
  tcas_pkg::side_t      side4;

  // stage 5: partial products of the squares
  logic [PW-1:0]        hh_x, hl_x, ll_x, hh_y, hl_y, ll_y, hh_z, hl_z, ll_z;
  logic signed [NW-1:0] nz5;
  tcas_pkg::side_t      side5;

  // stage 6: squares
  logic [XW-1:0]        sq_x, sq_y, sq_z;
  logic signed [NW-1:0] nz6;
  tcas_pkg::side_t      side6;

  logic [QW-1:0] mg_x, mg_y, mg_z;
  logic [QW-1:0] qv_x, qv_y, qv_z;
  logic [MW-1:0] m_x, m_y, m_z;

  // magnitudes of the coordinate sums and normal components, and the centroid quotients
  always_comb begin
    mg_x = QW'(sm_x[SW-1] ? -sm_x : sm_x);
    mg_y = QW'(sm_y[SW-1] ? -sm_y : sm_y);
    mg_z = QW'(sm_z[SW-1] ? -sm_z : sm_z);
    qv_x = q_x[QP-1:QS];
    qv_y = q_y[QP-1:QS];
    qv_z = q_z[QP-1:QS];
    m_x  = MW'(n_x[NW-1] ? -n_x : n_x);
    m_y  = MW'(n_y[NW-1] ? -n_y : n_y);
    m_z  = MW'(n_z[NW-1] ? -n_z : n_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= tri_in;

      ab_x <= DW'(p0.first_x) - DW'(p0.second_x);
      ab_y <= DW'(p0.first_y) - DW'(p0.second_y);
      ab_z <= DW'(p0.first_z) - DW'(p0.second_z);
      ac_x <= DW'(p0.first_x) - DW'(p0.third_x);
      ac_y <= DW'(p0.first_y) - DW'(p0.third_y);
      ac_z <= DW'(p0.first_z) - DW'(p0.third_z);
      sm_x <= SW'(p0.first_x) + SW'(p0.second_x) + SW'(p0.third_x);
      sm_y <= SW'(p0.first_y) + SW'(p0.second_y) + SW'(p0.third_y);
      sm_z <= SW'(p0.first_z) + SW'(p0.second_z) + SW'(p0.third_z);

      acy_abz <= ac_y * ab_z;
      acz_aby <= ac_z * ab_y;
      acz_abx <= ac_z * ab_x;
      acx_abz <= ac_x * ab_z;
      acx_aby <= ac_x * ab_y;
      acy_abx <= ac_y * ab_x;
      q_x     <= QP'(mg_x) * QP'(tcas_pkg::Recip3);
      q_y     <= QP'(mg_y) * QP'(tcas_pkg::Recip3);
      q_z     <= QP'(mg_z) * QP'(tcas_pkg::Recip3);
      neg_x3  <= sm_x[SW-1];
      neg_y3  <= sm_y[SW-1];
      neg_z3  <= sm_z[SW-1];

      n_x <= NW'(acy_abz) - NW'(acz_aby);
      n_y <= NW'(acz_abx) - NW'(acx_abz);
      n_z <= NW'(acx_aby) - NW'(acy_abx);
      side4.cx    <= CW'(neg_x3 ? (QW'(0) - qv_x) : qv_x);
      side4.cy    <= CW'(neg_y3 ? (QW'(0) - qv_y) : qv_y);
      side4.cz    <= CW'(neg_z3 ? (QW'(0) - qv_z) : qv_z);
      side4.degen <= 1'b0;

      // split each magnitude in halves so every multiplier stays narrow
      hh_x <= PW'(m_x[MW-1:HW]) * PW'(m_x[MW-1:HW]);
      hl_x <= PW'(m_x[MW-1:HW]) * PW'(m_x[HW-1:0]);
      ll_x <= PW'(m_x[HW-1:0]) * PW'(m_x[HW-1:0]);
      hh_y <= PW'(m_y[MW-1:HW]) * PW'(m_y[MW-1:HW]);
      hl_y <= PW'(m_y[MW-1:HW]) * PW'(m_y[HW-1:0]);
      ll_y <= PW'(m_y[HW-1:0]) * PW'(m_y[HW-1:0]);
      hh_z <= PW'(m_z[MW-1:HW]) * PW'(m_z[MW-1:HW]);
      hl_z <= PW'(m_z[MW-1:HW]) * PW'(m_z[HW-1:0]);
      ll_z <= PW'(m_z[HW-1:0]) * PW'(m_z[HW-1:0]);
      nz5         <= n_z;
      side5.cx    <= side4.cx;
      side5.cy    <= side4.cy;
      side5.cz    <= side4.cz;
      side5.degen <= (n_x == '0) && (n_y == '0) && (n_z == '0);

      sq_x  <= (XW'(hh_x) << (2 * HW)) + (XW'(hl_x) << (HW + 1)) + XW'(ll_x);
      sq_y  <= (XW'(hh_y) << (2 * HW)) + (XW'(hl_y) << (HW + 1)) + XW'(ll_y);
      sq_z  <= (XW'(hh_z) << (2 * HW)) + (XW'(hl_z) << (HW + 1)) + XW'(ll_z);
      nz6   <= nz5;
      side6 <= side5;

      sum_xy  <= sq_x + sq_y;
      sum_all <= sq_x + sq_y + sq_z;
      norm_z  <= nz6;
      side    <= side6;
    end
  end

endmodule

### rtl/core/tcas_isqrt.sv
// tcas_isqrt: pipelined integer square root, one result bit per stage
// depends on tcas_pkg
module tcas_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tcas_pkg::SqW-1:0]    rad_in,
  output logic [tcas_pkg::RootW-1:0]  root_out
);

  localparam int SW = tcas_pkg::SqW;
  localparam int RW = tcas_pkg::RootW;
  localparam int TW = SW + 2;

  logic [SW-1:0] rad  [0:RW];
  logic [RW-1:0] root [0:RW];
  logic [TW-1:0] sq   [0:RW];

  assign rad[0]   = rad_in;
  assign root[0]  = '0;
  assign sq[0]    = '0;
  assign root_out = root[RW];

  // each stage tries one bit, tracking root squared to avoid a multiplier
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [TW-1:0] trial;

    assign trial = sq[k] + (TW'(root[k]) << (B + 1)) + (TW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1] <= rad[k];
        if (trial <= TW'(rad[k])) begin
          root[k+1] <= root[k] | (RW'(1) << B);
          sq[k+1]   <= trial;
        end else begin
          root[k+1] <= root[k];
          sq[k+1]   <= sq[k];
        end
      end
    end
  end

endmodule

### rtl/core/tcas_cordic.sv
// tcas_cordic: slope angle by vectoring cordic with operand normalization
// depends on tcas_pkg
module tcas_cordic (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [tcas_pkg::NormW-1:0]    norm_z,
  input  logic [tcas_pkg::RootW-1:0]           horiz,
  output logic [tcas_pkg::SlopeW-1:0]          slope
);

  localparam int NW = tcas_pkg::NormW;
  localparam int XW = tcas_pkg::CordW;
  localparam int AW = tcas_pkg::AngW;
  localparam int UW = tcas_pkg::NormMsb + 1;
  localparam int ST = tcas_pkg::Steps;
  localparam int HW = tcas_pkg::ShW;

  logic [UW-1:0] ux_c, uy_c, big_c, ux, uy;
  logic [HW-1:0] sh_c, sh;
  logic signed [AW-1:0] z0;

  logic signed [XW-1:0] cx [0:ST];
  logic signed [XW-1:0] cy [0:ST];
  logic signed [AW-1:0] cz [0:ST];
  logic signed [AW-1:0] zc;
  logic [AW-1:0]        zr;

  // quadrant choice and leading-one search
  always_comb begin
    if (norm_z[NW-1]) begin
      ux_c = UW'(horiz);
      uy_c = UW'(-norm_z);
    end else begin
      ux_c = UW'(norm_z);
      uy_c = UW'(horiz);
    end
    big_c = (ux_c > uy_c) ? ux_c : uy_c;
    sh_c  = '0;
    for (int i = 0; i < UW; i++) begin
      if (big_c[i]) sh_c = HW'(UW - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= ux_c;
      uy <= uy_c;
      sh <= sh_c;
      z0 <= norm_z[NW-1] ? tcas_pkg::Angle90 : '0;
      cx[0] <= XW'(ux << sh);
      cy[0] <= XW'(uy << sh);
      cz[0] <= z0;
    end
  end

  // rotation steps
  for (genvar i = 0; i < ST; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][XW-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + tcas_pkg::atan_q16(i);
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - tcas_pkg::atan_q16(i);
        end
      end
    end
  end

  // clamp to the half turn and round to q8
  always_comb begin
    if (cz[ST][AW-1]) zc = '0;
    else if (cz[ST] > tcas_pkg::Angle180) zc = tcas_pkg::Angle180;
    else zc = cz[ST];
    zr = AW'(zc) + AW'(128);
  end

  always_ff @(posedge clk) begin
    if (en) slope <= zr[tcas_pkg::SlopeW+7:8];
  end

endmodule

### rtl/core/triangle_centroid_area_slope.sv
// triangle_centroid_area_slope: top level, one triangle in, one result out
// pipeline: 7 cross product stages, 35 square root stages, 21 cordic stages
// throughput one triangle per cycle; a stalled result holds the whole pipeline
// reset (rst, synchronous) clears the valid bits only; payload is not reset
// the input is stalled while rst is high
// depends on tcas_pkg, tcas_cross, tcas_isqrt, tcas_cordic
module triangle_centroid_area_slope (
  input  logic               clk,
  input  logic               rst,
  input  logic               triangle_valid,
  output logic               triangle_stall,
  input  tcas_pkg::tri_in_t  triangle,
  output logic               result_valid,
  input  logic               result_stall,
  output tcas_pkg::tri_out_t result
);

  localparam int LAT = tcas_pkg::TotalLat;
  localparam int RL  = tcas_pkg::RootW;
  localparam int CL  = tcas_pkg::CordLat;

  logic en;
  logic [LAT-1:0] vld;

  logic [tcas_pkg::SqW-1:0]             sum_all, sum_xy;
  logic signed [tcas_pkg::NormW-1:0]    nz_x, nz_d [0:RL-1];
  tcas_pkg::side_t                      side_x;
  tcas_pkg::side_t                      side_d [0:RL+CL-1];
  logic [tcas_pkg::RootW-1:0]           root_all, root_xy;
  logic [tcas_pkg::RootW-1:0]           root_d [0:CL-1];
  logic [tcas_pkg::SlopeW-1:0]          slope;

  // pipeline advances unless a finished result is held
  assign en             = !(vld[LAT-1] && result_stall);
  assign triangle_stall = rst || !en;
  assign result_valid   = vld[LAT-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], triangle_valid};
    end
  end

  tcas_cross u_cross (
    .clk     (clk),
    .en      (en),
    .tri_in  (triangle),
    .sum_all (sum_all),
    .sum_xy  (sum_xy),
    .norm_z  (nz_x),
    .side    (side_x)
  );

  tcas_isqrt u_root_all (
    .clk      (clk),
    .en       (en),
    .rad_in   (sum_all),
    .root_out (root_all)
  );

  tcas_isqrt u_root_xy (
    .clk      (clk),
    .en       (en),
    .rad_in   (sum_xy),
    .root_out (root_xy)
  );

  tcas_cordic u_cordic (
    .clk    (clk),
    .en     (en),
    .norm_z (nz_d[RL-1]),
    .horiz  (root_xy),
    .slope  (slope)
  );

  // delay lines aligning side data with the root and cordic stages
  always_ff @(posedge clk) begin
    if (en) begin
      nz_d[0]   <= nz_x;
      side_d[0] <= side_x;
      root_d[0] <= root_all;
      for (int i = 1; i < RL; i++) nz_d[i] <= nz_d[i-1];
      for (int i = 1; i < RL + CL; i++) side_d[i] <= side_d[i-1];
      for (int i = 1; i < CL; i++) root_d[i] <= root_d[i-1];
    end
  end

  // result assembly
  always_comb begin
    result.center_x      = side_d[RL+CL-1].cx;
    result.center_y      = side_d[RL+CL-1].cy;
    result.center_z      = side_d[RL+CL-1].cz;
    result.area          = tcas_pkg::AreaW'(root_d[CL-1] >> 1);
    result.degenerate    = side_d[RL+CL-1].degen;
    result.slope_degrees = side_d[RL+CL-1].degen ? '0 : slope;
  end

endmodule

### sim/tb.sv
// tb: self-checking bench for triangle_centroid_area_slope, random idling on both sides
// predicts centroid, area, slope and degenerate flag per triangle unless typed in; depends on tcas_pkg
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomFaces = 1750;
  localparam int Latency     = 63;
  localparam int CycleLimit  = 400000;

  typedef struct {
    tcas_pkg::tri_in_t  face;
    bit                 typed;
    tcas_pkg::tri_out_t want;
  } face_row_t;

  logic               clk;
  logic               rst;
  logic               triangle_valid;
  logic               triangle_stall;
  tcas_pkg::tri_in_t  triangle;
  logic               result_valid;
  logic               result_stall;
  tcas_pkg::tri_out_t result;

  tcas_pkg::tri_out_t pending_faces[$];
  face_row_t          directed_faces[$];
  int        mismatches = 0;
  int        faces_sent = 0;
  int        faces_checked = 0;
  int        flat_faces = 0;
  int        cycles = 0;
  bit        calm_sink = 0;

  triangle_centroid_area_slope i_dut (
    .clk, .rst, .triangle_valid, .triangle_stall, .triangle,
    .result_valid, .result_stall, .result
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[triangle_centroid_area_slope] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] root_floor(logic [79:0] s);
    logic [63:0] r;
    logic [79:0] c;
    r = '0;
    for (int b = 39; b >= 0; b--) begin
      c = 80'(r | (64'd1 << b));
      if (c * c <= s) r = c[63:0];
    end
    return r;
  endfunction

  // vectoring cordic, degrees q16, rounded to q8
  function automatic logic [15:0] tilt_angle(longint nz, logic [63:0] h);
    logic [63:0] ux, uy, big;
    longint x, y, z, dx, dy;
    z = 0;
    if (nz < 0) begin
      ux = h;
      uy = 64'(-nz);
      z = longint'(90) << 16;
    end else begin
      ux = 64'(nz);
      uy = h;
    end
    big = (ux > uy) ? ux : uy;
    while (big < (64'd1 << 39)) begin
      ux = ux << 1; uy = uy << 1; big = big << 1;
    end
    while (big >= (64'd1 << 40)) begin
      ux = ux >> 1; uy = uy >> 1; big = big >> 1;
    end
    x = longint'(ux);
    y = longint'(uy);
    for (int i = 0; i < tcas_pkg::Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(tcas_pkg::atan_q16(i));
      end else begin
        x -= dx; y += dy; z -= longint'(tcas_pkg::atan_q16(i));
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(180) << 16)) z = longint'(180) << 16;
    return 16'((z + 128) >>> 8);
  endfunction

  function automatic tcas_pkg::tri_out_t predict_face(tcas_pkg::tri_in_t t);
    longint v[9];
    longint abx, aby, abz, acx, acy, acz, nx, ny, nz;
    logic [79:0] mx, my, mz, sxy;
    logic [63:0] a;
    tcas_pkg::tri_out_t o;
    v = '{longint'(t.first_x), longint'(t.first_y), longint'(t.first_z),
          longint'(t.second_x), longint'(t.second_y), longint'(t.second_z),
          longint'(t.third_x), longint'(t.third_y), longint'(t.third_z)};
    o.center_x = 16'((v[0] + v[3] + v[6]) / 3);
    o.center_y = 16'((v[1] + v[4] + v[7]) / 3);
    o.center_z = 16'((v[2] + v[5] + v[8]) / 3);
    abx = v[0] - v[3]; aby = v[1] - v[4]; abz = v[2] - v[5];
    acx = v[0] - v[6]; acy = v[1] - v[7]; acz = v[2] - v[8];
    nx = acy * abz - acz * aby;
    ny = acz * abx - acx * abz;
    nz = acx * aby - acy * abx;
    mx = 80'(nx < 0 ? -nx : nx);
    my = 80'(ny < 0 ? -ny : ny);
    mz = 80'(nz < 0 ? -nz : nz);
    sxy = mx * mx + my * my;
    a = root_floor(sxy + mz * mz) >> 1;
    if (a > 64'h7_FFFF_FFFF) a = 64'h7_FFFF_FFFF;
    o.area = a[tcas_pkg::AreaW-1:0];
    if (nx == 0 && ny == 0 && nz == 0) begin
      o.slope_degrees = '0;
      o.degenerate = 1'b1;
    end else begin
      o.slope_degrees = tilt_angle(nz, root_floor(sxy));
      o.degenerate = 1'b0;
    end
    return o;
  endfunction

  function automatic tcas_pkg::tri_in_t make_face(int ax, int ay, int az,
                                                  int bx, int by, int bz,
                                                  int cx, int cy, int cz);
    return tcas_pkg::tri_in_t'{16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
                               16'(cx), 16'(cy), 16'(cz)};
  endfunction

  function automatic tcas_pkg::tri_out_t make_flat(int cx, int cy, int cz);
    return tcas_pkg::tri_out_t'{16'(cx), 16'(cy), 16'(cz), 35'd0, 16'd0, 1'b1};
  endfunction

  // random coordinate, full range when span is 0, else within plus or minus span
  function automatic int rand_coord(int span);
    if (span == 0) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic tcas_pkg::tri_in_t rand_face();
    int kind, span;
    int p[9];
    kind = $urandom_range(9);
    case ($urandom_range(3))
      0: span = 4;
      1: span = 1024;
      default: span = 0;
    endcase
    foreach (p[i]) p[i] = rand_coord(span);
    case (kind)
      // repeated vertex
      0: begin p[6] = p[0]; p[7] = p[1]; p[8] = p[2]; end
      // level face, normal straight up or down
      1: begin p[5] = p[2]; p[8] = p[2]; end
      // upright face, normal horizontal
      2: begin p[3] = p[0]; p[6] = p[0]; end
      // collinear: third on the line through first and second, when in range
      3: begin
        if (span != 0) begin
          p[6] = 2 * p[3] - p[0]; p[7] = 2 * p[4] - p[1]; p[8] = 2 * p[5] - p[2];
        end
      end
      default: ;
    endcase
    return make_face(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
  endfunction

  task automatic send_face(tcas_pkg::tri_in_t f, bit typed, tcas_pkg::tri_out_t want,
                           int gap);
    if (gap > 0) begin
      triangle_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    triangle_valid <= 1'b1;
    triangle <= f;
    do @(posedge clk); while (triangle_stall);
    pending_faces.push_back(typed ? want : predict_face(f));
    faces_sent++;
  endtask

  // result sink with random stall per transaction
  initial begin
    int n;
    result_stall = 1'b1;
    @(negedge rst);
    forever begin
      n = calm_sink ? 0 : $urandom_range(17);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  // result checker
  always @(posedge clk) begin
    tcas_pkg::tri_out_t e;
    if (!rst && result_valid && !result_stall) begin
      if (pending_faces.size() == 0) begin
        $error("result with no triangle outstanding: %p", result);
        mismatches++;
      end else begin
        e = pending_faces.pop_front();
        faces_checked++;
        if (e.degenerate) flat_faces++;
        if (result.center_x !== e.center_x) begin
          $error("center_x expected %0d got %0d", e.center_x, result.center_x);
          mismatches++;
        end
        if (result.center_y !== e.center_y) begin
          $error("center_y expected %0d got %0d", e.center_y, result.center_y);
          mismatches++;
        end
        if (result.center_z !== e.center_z) begin
          $error("center_z expected %0d got %0d", e.center_z, result.center_z);
          mismatches++;
        end
        if (result.area !== e.area) begin
          $error("area expected %0d got %0d", e.area, result.area);
          mismatches++;
        end
        if (result.slope_degrees !== e.slope_degrees) begin
          $error("slope_degrees expected %0d got %0d", e.slope_degrees, result.slope_degrees);
          mismatches++;
        end
        if (result.degenerate !== e.degenerate) begin
          $error("degenerate expected %0d got %0d", e.degenerate, result.degenerate);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    tcas_pkg::tri_out_t none;
    int gap;
    bit calm_src;
    none = '0;
    rst = 1'b1;
    triangle_valid = 1'b0;
    triangle = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table: degenerate rows typed in, the rest predicted
    directed_faces.push_back('{make_face(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_flat(0, 0, 0)});
    directed_faces.push_back('{make_face(32767, 32767, 32767, 32767, 32767, 32767,
      32767, 32767, 32767), 1, make_flat(32767, 32767, 32767)});
    directed_faces.push_back('{make_face(-32768, -32768, -32768, -32768, -32768, -32768,
      -32768, -32768, -32768), 1, make_flat(-32768, -32768, -32768)});
    directed_faces.push_back('{make_face(-32768, -32768, -32768, -32768, -32768, -32768,
      32767, 32767, 32767), 1, make_flat(-10923, -10923, -10923)});
    directed_faces.push_back('{make_face(0, 0, 0, 256, 256, 256, 512, 512, 512), 1,
      make_flat(256, 256, 256)});
    directed_faces.push_back('{make_face(0, 0, 0, 256, 0, 0, 0, 256, 0), 0, none});
    directed_faces.push_back('{make_face(0, 0, 0, 0, 256, 0, 256, 0, 0), 0, none});
    directed_faces.push_back('{make_face(0, 0, 0, 256, 0, 0, 0, 0, 256), 0, none});
    directed_faces.push_back('{make_face(-32768, -32768, -32768, 32767, -32768, 32767,
      -32768, 32767, 32767), 0, none});
    directed_faces.push_back('{make_face(32767, -32768, 0, -32768, 32767, 0,
      -32768, -32768, 32767), 0, none});
    directed_faces.push_back('{make_face(-32768, 32767, -32768, 32767, -32768, -32768,
      32767, 32767, 32767), 0, none});
    directed_faces.push_back('{make_face(1, 0, 0, 0, 1, 0, 0, 0, 1), 0, none});
    directed_faces.push_back('{make_face(-1, -1, -1, 1, -1, -1, -1, 1, -2), 0, none});
    directed_faces.push_back('{make_face(100, 200, 300, 100, 200, 301, 101, 200, 300), 0, none});
    foreach (directed_faces[i])
      send_face(directed_faces[i].face, directed_faces[i].typed, directed_faces[i].want,
                $urandom_range(3));

    // random triangles, with stretches of back-to-back traffic
    calm_src = 0;
    for (int i = 0; i < RandomFaces; i++) begin
      if (i % 150 == 0) begin
        calm_src = ($urandom_range(2) == 0);
        calm_sink = ($urandom_range(2) == 0);
      end
      if (i == RandomFaces / 2) begin
        triangle_valid <= 1'b0;
        while (pending_faces.size() != 0) @(posedge clk);
      end
      gap = calm_src ? 0 : $urandom_range(17);
      send_face(rand_face(), 0, none, gap);
    end
    triangle_valid <= 1'b0;

    while (pending_faces.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("sent %0d triangles, checked %0d results, %0d of them degenerate",
             faces_sent, faces_checked, flat_faces);
    if (mismatches == 0 && pending_faces.size() == 0)
      $display("[triangle_centroid_area_slope] OK");
    else
      $display("[triangle_centroid_area_slope] ERROR");
    $finish;
  end

endmodule
